@@ design/bbr_pkg.sv @@
// shared types, constants and the reciprocal table for the 3x3 box blur
`default_nettype none

package bbr_pkg;

   localparam int PIX_W        = 8;
   localparam int RGB_W        = 3 * PIX_W;
   localparam int SUM_W        = 12;
   localparam int CNT_W        = 4;
   localparam int RECIP_W      = 17;
   localparam int RECIP_SHIFT  = 17;
   localparam int WIN_ROWS     = 3;
   localparam int WIN_TAPS     = 9;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 16;
   localparam int CSR_DATA_W   = 16;
   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   typedef logic [RGB_W-1:0] rgb_type;

   typedef struct packed {
      logic ok_left;
      logic ok_right;
      logic ok_top;
      logic ok_bottom;
      logic last;
   } tap_ctl_type;

   // ceil(2^17 / (2n)), exact for numerators below 2^17 / 18
   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
      logic [RECIP_W-1:0] r;
      case (n)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21846;
         4'd4:    r = 17'd16384;
         4'd5:    r = 17'd13108;
         4'd6:    r = 17'd10923;
         4'd7:    r = 17'd9363;
         4'd8:    r = 17'd8192;
         4'd9:    r = 17'd7282;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ design/bbr_norm.sv @@
// rounded average of one channel: (2*sum+n)/(2n) by reciprocal multiply, saturated
`default_nettype none

module bbr_norm (
   input  logic [bbr_pkg::SUM_W-1:0] sum,
   input  logic [bbr_pkg::CNT_W-1:0] cnt,
   output logic [bbr_pkg::PIX_W-1:0] avg
);

   localparam int NUM_W  = bbr_pkg::SUM_W + 1;
   localparam int PROD_W = NUM_W + bbr_pkg::RECIP_W;
   localparam int QUO_W  = PROD_W - bbr_pkg::RECIP_SHIFT;

   logic [NUM_W-1:0]  num;
   logic [PROD_W-1:0] prod;
   logic [QUO_W-1:0]  quo;

   assign num  = {sum, 1'b0} + NUM_W'(cnt);
   assign prod = PROD_W'(num) * PROD_W'(bbr_pkg::recip(cnt));
   assign quo  = prod[PROD_W-1:bbr_pkg::RECIP_SHIFT];
   assign avg  = (quo > QUO_W'(bbr_pkg::PIX_MAX)) ? bbr_pkg::PIX_MAX
                                                  : quo[bbr_pkg::PIX_W-1:0];

endmodule

`default_nettype wire

@@ design/box_blur_3x3_rgb.sv @@
// 3x3 rgb box blur over a raster pixel stream with two line stores in one memory
//
// requests enter on req_* in raster order; req_tuser low carries a pixel, high is a
// drain request. drain requests are dropped while pixels of the image are still due;
// once the image is complete every request shifts in a blank pixel and pushes out one
// result, so W+1 drain requests flush the final row. results leave on rsp_* with
// rsp_tlast on the final pixel of the image, after which counters restart.
// throughput is one request per clock while rsp_tready is high: each pixel does one read
// and one write of the line memory at its column, with a bypass when consecutive pixels
// share a column. the result for a pixel is produced by the request W+1 positions later
// and shows on rsp_tvalid once that request has passed memory read, window, sum, divide.
// reset restores 640x480 and clears counters and pipeline valids; the line memory is
// not cleared and needs no clearing pass. image size is written on csr_* between
// images. when rsp_tready is low the result is held, the pipeline keeps filling into
// empty stages, and req_tready drops once no stage can move.
`default_nettype none

module box_blur_3x3_rgb #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bbr_pkg::RGB_W-1:0]        req_tdata,  // red_in, green_in, blue_in
   input  logic                             req_tuser,  // req_type

   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bbr_pkg::RGB_W-1:0]        rsp_tdata,  // red_out, green_out, blue_out
   output logic                             rsp_tlast,

   input  logic                             csr_wr_en,
   input  logic                             csr_index,
   input  logic [bbr_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CMP_W = ($clog2(MAX_WIDTH + 1) > bbr_pkg::WIDTH_REG_W)
                          ? $clog2(MAX_WIDTH + 1) : bbr_pkg::WIDTH_REG_W;
   localparam int ROW_W = bbr_pkg::HEIGHT_REG_W + 1;
   localparam int MEM_W = 2 * bbr_pkg::RGB_W;
   localparam int PW    = bbr_pkg::PIX_W;
   localparam int SW    = bbr_pkg::SUM_W;
   localparam int CW    = bbr_pkg::CNT_W;
   localparam int HW    = bbr_pkg::HEIGHT_REG_W;

   function automatic logic [COL_W-1:0] width_m1(input logic [bbr_pkg::WIDTH_REG_W-1:0] v);
      logic [CMP_W-1:0] vz;
      vz = CMP_W'(v);
      if (vz == '0) begin
         return '0;
      end else if (vz >= CMP_W'(MAX_WIDTH)) begin
         return COL_W'(MAX_WIDTH - 1);
      end else begin
         return COL_W'(vz - 1'b1);
      end
   endfunction

   // image size
   logic [COL_W-1:0] w_m1_ff;
   logic [HW-1:0]    h_m1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_m1_ff <= width_m1(bbr_pkg::WIDTH_REG_W'(bbr_pkg::RESET_WIDTH));
         h_m1_ff <= HW'(bbr_pkg::RESET_HEIGHT - 1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bbr_pkg::CSR_IMAGE_WIDTH:
               w_m1_ff <= width_m1(csr_wdata[bbr_pkg::WIDTH_REG_W-1:0]);
            bbr_pkg::CSR_IMAGE_HEIGHT:
               h_m1_ff <= (csr_wdata[HW-1:0] == '0) ? '0 : csr_wdata[HW-1:0] - 1'b1;
            default: ;
         endcase
      end
   end

   // position counters
   logic [COL_W-1:0] col_ff, col_in, ocol_ff, ocol_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [HW-1:0]    orow_ff, orow_in;

   logic req_fire, in_image, drop, take, col_last, emit;
   logic ocol_last, orow_last, img_last;
   bbr_pkg::tap_ctl_type ctl_in;
   bbr_pkg::rgb_type     px_in;

   assign req_fire  = req_tvalid && req_tready;
   assign in_image  = row_ff <= ROW_W'(h_m1_ff);
   assign drop      = in_image && req_tuser;
   assign take      = req_fire && !drop;
   assign col_last  = col_ff == w_m1_ff;
   assign emit      = !((row_ff == '0) || ((row_ff == ROW_W'(1)) && (col_ff == '0)));
   assign ocol_last = ocol_ff == w_m1_ff;
   assign orow_last = orow_ff == h_m1_ff;
   assign img_last  = ocol_last && orow_last;
   assign px_in     = in_image ? req_tdata : '0;

   always_comb begin
      ctl_in.ok_left   = ocol_ff != '0;
      ctl_in.ok_right  = !ocol_last;
      ctl_in.ok_top    = orow_ff != '0;
      ctl_in.ok_bottom = !orow_last;
      ctl_in.last      = img_last;
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      if (take) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
         if (emit) begin
            if (img_last) begin
               col_in  = '0;
               row_in  = '0;
               ocol_in = '0;
               orow_in = '0;
            end else if (ocol_last) begin
               ocol_in = '0;
               orow_in = orow_ff + 1'b1;
            end else begin
               ocol_in = ocol_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         ocol_ff <= '0;
         orow_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         ocol_ff <= ocol_in;
         orow_ff <= orow_in;
      end
   end

   // stage 1: line memory read-modify-write
   logic                 s1_v_ff, s1_emit_ff, s1_fwd_ff, s1_fire;
   logic [COL_W-1:0]     s1_col_ff;
   bbr_pkg::rgb_type     s1_px_ff;
   logic [MEM_W-1:0]     s1_fwd_data_ff, rd_ff, cur_line, wr_data;
   bbr_pkg::tap_ctl_type s1_ctl_ff;
   bbr_pkg::rgb_type     upper, lower;
   logic [MEM_W-1:0]     line_mem [MAX_WIDTH];

   logic s2_v_ff, s2_fire;
   logic s3_v_ff, s3_fire;
   logic rsp_v_ff;

   assign s1_fire    = s1_v_ff && (!s2_v_ff || s2_fire);
   assign req_tready = !s1_v_ff || s1_fire;
   assign cur_line   = s1_fwd_ff ? s1_fwd_data_ff : rd_ff;
   assign upper      = cur_line[MEM_W-1:bbr_pkg::RGB_W];
   assign lower      = cur_line[bbr_pkg::RGB_W-1:0];
   assign wr_data    = {lower, s1_px_ff};

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         line_mem[s1_col_ff] <= wr_data;
      end
      if (take) begin
         rd_ff <= line_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (take) begin
         s1_v_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_px_ff       <= px_in;
         s1_col_ff      <= col_ff;
         s1_emit_ff     <= emit;
         s1_ctl_ff      <= ctl_in;
         s1_fwd_ff      <= s1_fire && (s1_col_ff == col_ff);
         s1_fwd_data_ff <= wr_data;
      end
   end

   // stage 2: 3x3 window, column 0 oldest, row 0 top
   bbr_pkg::rgb_type     win_ff [bbr_pkg::WIN_TAPS];
   bbr_pkg::tap_ctl_type s2_ctl_ff;

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         for (int i = 0; i < bbr_pkg::WIN_TAPS - bbr_pkg::WIN_ROWS; i++) begin
            win_ff[i] <= win_ff[i + bbr_pkg::WIN_ROWS];
         end
         win_ff[bbr_pkg::WIN_TAPS - 3] <= upper;
         win_ff[bbr_pkg::WIN_TAPS - 2] <= lower;
         win_ff[bbr_pkg::WIN_TAPS - 1] <= s1_px_ff;
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s1_fire && s1_emit_ff) begin
         s2_v_ff <= 1'b1;
      end else if (s2_fire) begin
         s2_v_ff <= 1'b0;
      end
   end

   assign s2_fire = s2_v_ff && (!s3_v_ff || s3_fire);

   logic [bbr_pkg::WIN_ROWS-1:0] col_ok, row_ok;
   logic [bbr_pkg::WIN_TAPS-1:0] tap_ok;
   logic [SW-1:0] sum_r_in, sum_g_in, sum_b_in;
   logic [CW-1:0] cnt_in;

   assign col_ok = {s2_ctl_ff.ok_right, 1'b1, s2_ctl_ff.ok_left};
   assign row_ok = {s2_ctl_ff.ok_bottom, 1'b1, s2_ctl_ff.ok_top};

   always_comb begin
      for (int c = 0; c < bbr_pkg::WIN_ROWS; c++) begin
         for (int r = 0; r < bbr_pkg::WIN_ROWS; r++) begin
            tap_ok[c * bbr_pkg::WIN_ROWS + r] = col_ok[c] && row_ok[r];
         end
      end
   end

   always_comb begin
      sum_r_in = '0;
      sum_g_in = '0;
      sum_b_in = '0;
      cnt_in   = '0;
      for (int i = 0; i < bbr_pkg::WIN_TAPS; i++) begin
         if (tap_ok[i]) begin
            sum_r_in = sum_r_in + SW'(win_ff[i][PW-1:0]);
            sum_g_in = sum_g_in + SW'(win_ff[i][2*PW-1:PW]);
            sum_b_in = sum_b_in + SW'(win_ff[i][3*PW-1:2*PW]);
            cnt_in   = cnt_in + 1'b1;
         end
      end
   end

   // stage 3: channel sums and tap count
   logic [SW-1:0] s3_sum_r_ff, s3_sum_g_ff, s3_sum_b_ff;
   logic [CW-1:0] s3_cnt_ff;
   logic          s3_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (s2_fire) begin
         s3_v_ff <= 1'b1;
      end else if (s3_fire) begin
         s3_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         s3_sum_r_ff <= sum_r_in;
         s3_sum_g_ff <= sum_g_in;
         s3_sum_b_ff <= sum_b_in;
         s3_cnt_ff   <= cnt_in;
         s3_last_ff  <= s2_ctl_ff.last;
      end
   end

   assign s3_fire = s3_v_ff && (!rsp_v_ff || rsp_tready);

   logic [PW-1:0] avg_r, avg_g, avg_b;

   bbr_norm u_norm_r (.sum(s3_sum_r_ff), .cnt(s3_cnt_ff), .avg(avg_r));
   bbr_norm u_norm_g (.sum(s3_sum_g_ff), .cnt(s3_cnt_ff), .avg(avg_g));
   bbr_norm u_norm_b (.sum(s3_sum_b_ff), .cnt(s3_cnt_ff), .avg(avg_b));

   // output register
   bbr_pkg::rgb_type rsp_data_ff;
   logic             rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (s3_fire) begin
         rsp_v_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_fire) begin
         rsp_data_ff <= {avg_b, avg_g, avg_r};
         rsp_last_ff <= s3_last_ff;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_image_end_restart: assert property (@(posedge clock) disable iff (reset)
      take && emit && img_last |=>
         col_ff == '0 && row_ff == '0 && ocol_ff == '0 && orow_ff == '0)
      else $error("counters not restarted after last pixel");

   a_tap_count_range: assert property (@(posedge clock) disable iff (reset)
      s3_v_ff |-> s3_cnt_ff != '0 && s3_cnt_ff <= CW'(bbr_pkg::WIN_TAPS))
      else $error("tap count out of range");

   a_window_held: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff && !s2_fire |=> !$past(s1_fire))
      else $error("window moved under a pending sum");

endmodule

`default_nettype wire
